### hdl/tmhq_pkg.sv
`timescale 1ns / 1ps
// Shared codes, control and status bundles for the timer min-heap queue.
// No dependencies; every other file imports this package.
package tmhq_pkg;

    typedef logic [1:0] cmd_t;
    typedef logic [2:0] kind_t;

    localparam cmd_t CMD_ADD    = 2'd0;
    localparam cmd_t CMD_CANCEL = 2'd1;
    localparam cmd_t CMD_TICK   = 2'd2;

    localparam kind_t KIND_ADDED     = 3'd0;
    localparam kind_t KIND_FULL      = 3'd1;
    localparam kind_t KIND_CANCELLED = 3'd2;
    localparam kind_t KIND_NOT_FOUND = 3'd3;
    localparam kind_t KIND_FIRED     = 3'd4;
    localparam kind_t KIND_IDLE      = 3'd5;

    localparam int MAX_FIRES = 64;
    localparam int FIRE_W    = $clog2(MAX_FIRES + 1);

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic  ready;
        logic  latch_in;
        logic  add_init;
        logic  rearm_init;
        logic  tick_inc;
        logic  up_read;
        logic  up_step;
        logic  place;
        logic  top_read;
        logic  top_latch;
        logic  pop_read;
        logic  pop_load;
        logic  down_read;
        logic  down_step;
        logic  scan_read;
        logic  scan_next;
        logic  cancel_wr;
        logic  fire;
        logic  emit;
        kind_t emit_kind;
        logic  emit_last;
    } ctl_t;

    // Status from the datapath back to the sequencer.
    typedef struct packed {
        cmd_t cmd;
        logic full;
        logic empty;
        logic idx_zero;
        logic up_swap;
        logic sd_leaf;
        logic sd_stop;
        logic scan_end;
        logic scan_hit;
        logic top_live;
        logic top_due;
        logic fire_ok;
        logic top_periodic;
        logic pend_valid;
        logic out_free;
    } sts_t;

endpackage

### hdl/tmhq_if.sv
`timescale 1ns / 1ps
// Request and result channel interfaces of the timer min-heap queue.
// Depends on tmhq_pkg.
interface tmhq_req_if;
    import tmhq_pkg::*;
    logic        valid;
    logic        ready;
    cmd_t        command;
    logic [31:0] delay;
    logic [31:0] period;
    logic [15:0] timer_id;
    modport source (output valid, command, delay, period, timer_id, input ready);
    modport sink (input valid, command, delay, period, timer_id, output ready);
endinterface

interface tmhq_res_if;
    import tmhq_pkg::*;
    logic        valid;
    logic        ready;
    kind_t       kind;
    logic [15:0] timer_id_res;
    logic        last;
    modport source (output valid, kind, timer_id_res, last, input ready);
    modport sink (input valid, kind, timer_id_res, last, output ready);
endinterface

### hdl/timer_min_heap_queue_top.sv
`timescale 1ns / 1ps
// Top level of the timer min-heap queue: sequencer plus datapath.
// Depends on tmhq_pkg, tmhq_if, tmhq_ctrl and tmhq_dp.
//
//  channel | dir | payload                         | transfer
//  req     | in  | command, delay, period, timer_id | valid && ready
//  res     | out | kind, timer_id_res, last         | valid && ready
//
// One item at a time: req.ready is high only while the sequencer is idle.
// Add: walks the new entry up one heap level per read and compare step,
// bounded by the single-write heap memory. Cancel: reads and checks each entry.
// Tick: pops each due or cancelled entry from the root and sifts down, plus re-arm walks.
// Reset clears counters and the clock at once; the heap memory needs no clear.
// A stalled result port holds the sequencer only when a new result must leave.
module timer_min_heap_queue_top #(
    parameter int CAPACITY  = 64,
    parameter int TIME_BITS = 48,
    parameter int ID_BITS   = 16
) (
    input logic          clk,
    input logic          rst_n,
    tmhq_req_if.sink     req,
    tmhq_res_if.source   res
);
    import tmhq_pkg::*;

    ctl_t ctl;
    sts_t sts;

    // Sequencer: decode each item and walk the heap one level at a time.
    tmhq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .sts      (sts),
        .ctl      (ctl)
    );

    // Accept an item only in the idle state.
    assign req.ready = ctl.ready;

    // Datapath: heap memory, clock, id counter and the result register.
    tmhq_dp #(
        .CAPACITY  (CAPACITY),
        .TIME_BITS (TIME_BITS),
        .ID_BITS   (ID_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (ctl),
        .sts              (sts),
        .in_command       (req.command),
        .in_delay         (req.delay),
        .in_period        (req.period),
        .in_timer_id      (req.timer_id),
        .out_valid        (res.valid),
        .out_ready        (res.ready),
        .out_kind         (res.kind),
        .out_timer_id_res (res.timer_id_res),
        .out_last         (res.last)
    );

endmodule

### hdl/tmhq_dp.sv
`timescale 1ns / 1ps
// Datapath: heap memory, counters, clock, moving entry and result register.
// Depends on tmhq_pkg; driven by tmhq_ctrl.
module tmhq_dp #(
    parameter int CAPACITY  = 64,
    parameter int TIME_BITS = 48,
    parameter int ID_BITS   = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tmhq_pkg::ctl_t        ctl,
    output tmhq_pkg::sts_t        sts,
    input  tmhq_pkg::cmd_t        in_command,
    input  logic [31:0]           in_delay,
    input  logic [31:0]           in_period,
    input  logic [15:0]           in_timer_id,
    output logic                  out_valid,
    input  logic                  out_ready,
    output tmhq_pkg::kind_t       out_kind,
    output logic [15:0]           out_timer_id_res,
    output logic                  out_last
);
    import tmhq_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef struct packed {
        logic                 live;
        logic [ID_BITS-1:0]   id;
        logic [31:0]          per;
        logic [TIME_BITS-1:0] dl;
    } entry_t;

    entry_t mem [CAPACITY];
    entry_t rd_a_reg, rd_b_reg;

    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [ID_BITS-1:0]   next_id_reg, next_id_next;
    logic [ID_BITS-1:0]   new_id_reg, new_id_next;
    logic [TIME_BITS-1:0] clock_reg, clock_next;
    logic [FIRE_W-1:0]    fired_reg, fired_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [ID_BITS-1:0]   pend_id_reg, pend_id_next;
    entry_t               e_reg, e_next;
    entry_t               top_reg, top_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [31:0]          delay_reg, delay_next;
    logic [31:0]          period_reg, period_next;
    logic [15:0]          tid_reg, tid_next;
    logic                 out_valid_reg, out_valid_next;
    kind_t                out_kind_reg, out_kind_next;
    logic [15:0]          out_id_reg, out_id_next;
    logic                 out_last_reg, out_last_next;

    logic [CNT_W-1:0]     parent;
    logic [CNT_W:0]       left_w, right_w;
    logic                 l_lt, r_ok;
    logic [31:0]          add_arg;
    logic [TIME_BITS:0]   sum_w;
    logic [TIME_BITS-1:0] sat_dl;
    logic [ID_BITS-1:0]   id_inc;
    logic                 we;
    logic [IDX_W-1:0]     waddr, ra, rb;
    entry_t               wdata;
    logic [15:0]          emit_id;

    assign parent  = (idx_reg - CNT_W'(1)) >> 1;
    assign left_w  = {idx_reg, 1'b1};
    assign right_w = left_w + (CNT_W + 1)'(1);
    assign l_lt    = rd_a_reg.dl < e_reg.dl;
    assign r_ok    = (right_w < {1'b0, cnt_reg})
                   && (rd_b_reg.dl < (l_lt ? rd_a_reg.dl : e_reg.dl));

    // Saturating deadline adder, shared by add and re-arm.
    assign add_arg = ctl.rearm_init ? top_reg.per : delay_reg;
    assign sum_w   = {1'b0, clock_reg} + (TIME_BITS + 1)'(add_arg);
    assign sat_dl  = sum_w[TIME_BITS] ? {TIME_BITS{1'b1}} : sum_w[TIME_BITS-1:0];
    assign id_inc  = next_id_reg + ID_BITS'(1);

    always_comb
    begin
        sts.cmd          = cmd_reg;
        sts.full         = cnt_reg == CNT_W'(CAPACITY);
        sts.empty        = cnt_reg == '0;
        sts.idx_zero     = idx_reg == '0;
        sts.up_swap      = rd_a_reg.dl > e_reg.dl;
        sts.sd_leaf      = left_w >= {1'b0, cnt_reg};
        sts.sd_stop      = !l_lt && !r_ok;
        sts.scan_end     = (idx_reg >= cnt_reg) || (tid_reg == '0);
        sts.scan_hit     = 32'(rd_a_reg.id) == 32'(tid_reg);
        sts.top_live     = rd_a_reg.live;
        sts.top_due      = rd_a_reg.dl <= clock_reg;
        sts.fire_ok      = fired_reg < FIRE_W'(MAX_FIRES);
        sts.top_periodic = top_reg.per != '0;
        sts.pend_valid   = pend_valid_reg;
        sts.out_free     = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = idx_reg[IDX_W-1:0];
        wdata = e_reg;
        if (ctl.place)
        begin
            we = 1'b1;
        end
        if (ctl.up_step)
        begin
            we    = 1'b1;
            wdata = rd_a_reg;
        end
        if (ctl.down_step)
        begin
            we    = 1'b1;
            wdata = r_ok ? rd_b_reg : rd_a_reg;
        end
        if (ctl.cancel_wr)
        begin
            we         = 1'b1;
            wdata      = rd_a_reg;
            wdata.live = 1'b0;
        end

        ra = idx_reg[IDX_W-1:0];
        rb = right_w[IDX_W-1:0];
        if (ctl.up_read)
        begin
            ra = parent[IDX_W-1:0];
        end
        if (ctl.top_read)
        begin
            ra = '0;
        end
        if (ctl.pop_read)
        begin
            ra = IDX_W'(cnt_reg - CNT_W'(1));
        end
        if (ctl.down_read)
        begin
            ra = left_w[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_a_reg <= mem[ra];
        rd_b_reg <= mem[rb];
    end

    always_comb
    begin
        case (out_kind_next)
            KIND_ADDED:     emit_id = 16'(new_id_reg);
            KIND_CANCELLED: emit_id = tid_reg;
            KIND_FIRED:     emit_id = 16'(pend_id_reg);
            default:        emit_id = '0;
        endcase
    end

    always_comb
    begin
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        next_id_next    = next_id_reg;
        new_id_next     = new_id_reg;
        clock_next      = clock_reg;
        fired_next      = fired_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        e_next          = e_reg;
        top_next        = top_reg;
        cmd_next        = cmd_reg;
        delay_next      = delay_reg;
        period_next     = period_reg;
        tid_next        = tid_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_kind_next   = ctl.emit ? ctl.emit_kind : out_kind_reg;
        out_last_next   = out_last_reg;
        out_id_next     = out_id_reg;

        if (ctl.latch_in)
        begin
            cmd_next    = in_command;
            delay_next  = in_delay;
            period_next = in_period;
            tid_next    = in_timer_id;
            idx_next    = '0;
        end
        if (ctl.add_init || ctl.rearm_init)
        begin
            e_next.live = 1'b1;
            e_next.dl   = sat_dl;
            e_next.per  = ctl.rearm_init ? top_reg.per : period_reg;
            e_next.id   = ctl.rearm_init ? top_reg.id : next_id_reg;
            idx_next    = cnt_reg;
            cnt_next    = cnt_reg + CNT_W'(1);
        end
        if (ctl.add_init)
        begin
            new_id_next  = next_id_reg;
            next_id_next = (id_inc == '0) ? ID_BITS'(1) : id_inc;
        end
        if (ctl.up_step)
        begin
            idx_next = parent;
        end
        if (ctl.top_latch)
        begin
            top_next = rd_a_reg;
        end
        if (ctl.pop_read)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
        if (ctl.pop_load)
        begin
            e_next   = rd_a_reg;
            idx_next = '0;
        end
        if (ctl.down_step)
        begin
            idx_next = r_ok ? right_w[CNT_W-1:0] : left_w[CNT_W-1:0];
        end
        if (ctl.scan_next)
        begin
            idx_next = idx_reg + CNT_W'(1);
        end
        if (ctl.tick_inc)
        begin
            clock_next      = clock_reg + TIME_BITS'(1);
            fired_next      = '0;
            pend_valid_next = 1'b0;
        end
        if (ctl.fire)
        begin
            pend_id_next    = top_reg.id;
            pend_valid_next = 1'b1;
            fired_next      = fired_reg + FIRE_W'(1);
        end
        if (ctl.emit)
        begin
            out_valid_next = 1'b1;
            out_last_next  = ctl.emit_last;
            out_id_next    = emit_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            next_id_reg    <= ID_BITS'(1);
            clock_reg      <= '0;
            fired_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg        <= cnt_next;
            next_id_reg    <= next_id_next;
            clock_reg      <= clock_next;
            fired_reg      <= fired_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        new_id_reg   <= new_id_next;
        pend_id_reg  <= pend_id_next;
        e_reg        <= e_next;
        top_reg      <= top_next;
        cmd_reg      <= cmd_next;
        delay_reg    <= delay_next;
        period_reg   <= period_next;
        tid_reg      <= tid_next;
        out_kind_reg <= out_kind_next;
        out_id_reg   <= out_id_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid        = out_valid_reg;
    assign out_kind         = out_kind_reg;
    assign out_timer_id_res = out_id_reg;
    assign out_last         = out_last_reg;

endmodule

### hdl/tmhq_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for add, cancel and tick: drives heap walks and result emission.
// Depends on tmhq_pkg; controls tmhq_dp.
module tmhq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  tmhq_pkg::sts_t sts,
    output tmhq_pkg::ctl_t ctl
);
    import tmhq_pkg::*;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_DISP    = 5'd1;
    localparam logic [4:0] S_ADD     = 5'd2;
    localparam logic [4:0] S_SU_READ = 5'd3;
    localparam logic [4:0] S_SU_CMP  = 5'd4;
    localparam logic [4:0] S_EM_ADD  = 5'd5;
    localparam logic [4:0] S_EM_FULL = 5'd6;
    localparam logic [4:0] S_C_READ  = 5'd7;
    localparam logic [4:0] S_C_CHK   = 5'd8;
    localparam logic [4:0] S_EM_CAN  = 5'd9;
    localparam logic [4:0] S_EM_NF   = 5'd10;
    localparam logic [4:0] S_T_START = 5'd11;
    localparam logic [4:0] S_T_TOP   = 5'd12;
    localparam logic [4:0] S_T_DEC   = 5'd13;
    localparam logic [4:0] S_POP     = 5'd14;
    localparam logic [4:0] S_SD_READ = 5'd15;
    localparam logic [4:0] S_SD_CMP  = 5'd16;
    localparam logic [4:0] S_T_FIRE  = 5'd17;
    localparam logic [4:0] S_T_END   = 5'd18;

    logic [4:0] state_reg, state_next;
    logic [4:0] ret_reg, ret_next;
    logic       phase2_reg, phase2_next;
    logic       do_pop;

    always_comb
    begin
        ctl         = '0;
        state_next  = state_reg;
        ret_next    = ret_reg;
        phase2_next = phase2_reg;
        do_pop      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                ctl.ready    = 1'b1;
                ctl.latch_in = in_valid;
                if (in_valid)
                begin
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (sts.cmd)
                    CMD_ADD:    state_next = S_ADD;
                    CMD_CANCEL: state_next = S_C_READ;
                    CMD_TICK:   state_next = S_T_START;
                    default:    state_next = S_IDLE;
                endcase
            end
            S_ADD:
            begin
                if (sts.full)
                begin
                    state_next = S_EM_FULL;
                end
                else
                begin
                    ctl.add_init = 1'b1;
                    ret_next     = S_EM_ADD;
                    state_next   = S_SU_READ;
                end
            end
            S_SU_READ:
            begin
                if (sts.idx_zero)
                begin
                    ctl.place  = 1'b1;
                    state_next = ret_reg;
                end
                else
                begin
                    ctl.up_read = 1'b1;
                    state_next  = S_SU_CMP;
                end
            end
            S_SU_CMP:
            begin
                if (sts.up_swap)
                begin
                    ctl.up_step = 1'b1;
                    state_next  = S_SU_READ;
                end
                else
                begin
                    ctl.place  = 1'b1;
                    state_next = ret_reg;
                end
            end
            S_C_READ:
            begin
                if (sts.scan_end)
                begin
                    state_next = S_EM_NF;
                end
                else
                begin
                    ctl.scan_read = 1'b1;
                    state_next    = S_C_CHK;
                end
            end
            S_C_CHK:
            begin
                if (sts.scan_hit)
                begin
                    ctl.cancel_wr = 1'b1;
                    state_next    = S_EM_CAN;
                end
                else
                begin
                    ctl.scan_next = 1'b1;
                    state_next    = S_C_READ;
                end
            end
            S_EM_ADD, S_EM_FULL, S_EM_CAN, S_EM_NF:
            begin
                if (sts.out_free)
                begin
                    ctl.emit      = 1'b1;
                    ctl.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
                unique case (state_reg)
                    S_EM_ADD:  ctl.emit_kind = KIND_ADDED;
                    S_EM_FULL: ctl.emit_kind = KIND_FULL;
                    S_EM_CAN:  ctl.emit_kind = KIND_CANCELLED;
                    default:   ctl.emit_kind = KIND_NOT_FOUND;
                endcase
            end
            S_T_START:
            begin
                ctl.tick_inc = 1'b1;
                phase2_next  = 1'b0;
                state_next   = S_T_TOP;
            end
            S_T_TOP:
            begin
                // Fetch the root; its data is valid in the next state.
                ctl.top_read = 1'b1;
                state_next   = S_T_DEC;
            end
            S_T_DEC:
            begin
                ctl.top_latch = 1'b1;
                state_next    = S_T_END;
                // An empty heap ends the tick at once.
                if (!sts.empty)
                begin
                    if (!phase2_reg && !sts.top_live)
                    begin
                        do_pop   = 1'b1;
                        ret_next = S_T_TOP;
                    end
                    else if (sts.top_due && sts.fire_ok)
                    begin
                        phase2_next = 1'b1;
                        do_pop      = 1'b1;
                        ret_next    = sts.top_live ? S_T_FIRE : S_T_TOP;
                    end
                    else
                    begin
                        phase2_next = 1'b1;
                    end
                end
                if (do_pop)
                begin
                    ctl.pop_read = 1'b1;
                    state_next   = S_POP;
                end
            end
            S_POP:
            begin
                ctl.pop_load = 1'b1;
                state_next   = S_SD_READ;
            end
            S_SD_READ:
            begin
                if (sts.sd_leaf)
                begin
                    ctl.place  = 1'b1;
                    state_next = ret_reg;
                end
                else
                begin
                    ctl.down_read = 1'b1;
                    state_next    = S_SD_CMP;
                end
            end
            S_SD_CMP:
            begin
                if (sts.sd_stop)
                begin
                    ctl.place  = 1'b1;
                    state_next = ret_reg;
                end
                else
                begin
                    ctl.down_step = 1'b1;
                    state_next    = S_SD_READ;
                end
            end
            S_T_FIRE:
            begin
                ctl.emit_kind = KIND_FIRED;
                if (!sts.pend_valid || sts.out_free)
                begin
                    ctl.fire = 1'b1;
                    ctl.emit = sts.pend_valid;
                    if (sts.top_periodic)
                    begin
                        ctl.rearm_init = 1'b1;
                        ret_next       = S_T_TOP;
                        state_next     = S_SU_READ;
                    end
                    else
                    begin
                        state_next = S_T_TOP;
                    end
                end
            end
            S_T_END:
            begin
                ctl.emit_kind = sts.pend_valid ? KIND_FIRED : KIND_IDLE;
                ctl.emit_last = 1'b1;
                if (sts.out_free)
                begin
                    ctl.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ret_reg    <= S_IDLE;
            phase2_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            phase2_reg <= phase2_next;
        end
    end

endmodule

### hdl/tmhq_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the timer min-heap queue, bound to the top level.
// Depends on tmhq_pkg and timer_min_heap_queue_top.
module tmhq_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  req_valid,
    input logic                  req_ready,
    input logic                  res_valid,
    input logic                  res_ready,
    input tmhq_pkg::kind_t       res_kind,
    input logic [15:0]           res_id,
    input logic                  res_last
);
    import tmhq_pkg::*;

    // A held result does not change.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_kind) && $stable(res_id))
        else $error("result changed while stalled");

    // After an accepted item the queue is not ready in the next cycle.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("item accepted on consecutive cycles");

    // Only fired results can be followed by more results of the same item.
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind != KIND_FIRED |-> res_last)
        else $error("non-fired result without last");

    // Full, not-found and idle results carry no id.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_kind == KIND_FULL || res_kind == KIND_NOT_FOUND
                      || res_kind == KIND_IDLE) |-> res_id == '0)
        else $error("id on a result that has none");

    // Added, cancelled and fired results always name a real timer.
    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_kind == KIND_ADDED || res_kind == KIND_CANCELLED
                      || res_kind == KIND_FIRED)
        |-> res_id != '0)
        else $error("zero id on added, cancelled or fired result");

endmodule

bind timer_min_heap_queue_top tmhq_checker u_tmhq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_kind  (res.kind),
    .res_id    (res.timer_id_res),
    .res_last  (res.last)
);
